[src/assert_macros.svh]
// assertion macros shared by the utf-8 repair block
// expects clk and rst to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define U8R_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define U8R_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/u8r_pkg.sv]
// shared types, constants and byte classification for the utf-8 repair block
// no dependencies
package u8r_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_RUN     = 6;

  localparam logic [7:0] CONT_MASK  = 8'hc0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] ASCII_TOP  = 8'h80;
  localparam logic [7:0] L2_MIN     = 8'hc2;
  localparam logic [7:0] L2_MAX     = 8'hdf;
  localparam logic [7:0] L3_MIN     = 8'he0;
  localparam logic [7:0] L3_MAX     = 8'hef;
  localparam logic [7:0] L4_MIN     = 8'hf0;
  localparam logic [7:0] L4_MAX     = 8'hf4;
  localparam logic [7:0] LEAD_E0    = 8'he0;
  localparam logic [7:0] LEAD_ED    = 8'hed;
  localparam logic [7:0] LEAD_F0    = 8'hf0;
  localparam logic [7:0] LEAD_F4    = 8'hf4;
  localparam logic [7:0] LIM_A0     = 8'ha0;
  localparam logic [7:0] LIM_90     = 8'h90;

  localparam logic [7:0] REPL_0 = 8'hef;
  localparam logic [7:0] REPL_1 = 8'hbf;
  localparam logic [7:0] REPL_2 = 8'hbd;

  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_1   = 3'd1;

  // one queued run of output bytes
  typedef struct packed {
    logic [MAX_RUN-1:0][7:0] bytes;
    logic [2:0]              count;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = LEN_BAD;
    if (b < ASCII_TOP) len = 3'd1;
    else if (b inside {[L2_MIN:L2_MAX]}) len = 3'd2;
    else if (b inside {[L3_MIN:L3_MAX]}) len = 3'd3;
    else if (b inside {[L4_MIN:L4_MAX]}) len = 3'd4;
    return len;
  endfunction

  function automatic logic continues(input logic [7:0] lead, input logic [1:0] pos,
                                     input logic [7:0] b);
    logic ok;
    ok = ((b & CONT_MASK) == CONT_TAG);
    if (pos == 2'd1) begin
      if (lead == LEAD_E0 && b < LIM_A0) ok = 1'b0;
      if (lead == LEAD_ED && b >= LIM_A0) ok = 1'b0;
      if (lead == LEAD_F0 && b < LIM_90) ok = 1'b0;
      if (lead == LEAD_F4 && b >= LIM_90) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

[src/u8r_in_if.sv]
// input channel: valid/ready handshake carrying mode and raw byte
// no dependencies
interface u8r_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] in_byte;

  modport source (output valid, output mode, output in_byte, input ready);
  modport sink (input valid, input mode, input in_byte, output ready);
endinterface

[src/u8r_out_if.sv]
// output channel: valid/ready handshake carrying one repaired byte
// no dependencies
interface u8r_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

[src/u8r_front.sv]
// front end: accepts requests, tracks the held prefix, builds output runs
// depends on u8r_pkg
module u8r_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              raw_valid,
  output logic              raw_ready,
  input  logic              mode,
  input  logic [7:0]        in_byte,
  input  u8r_pkg::q_stat_t  stat,
  output logic              push,
  output u8r_pkg::job_t     job
);

  logic [7:0] held_bytes [3];
  logic [1:0] held_count;
  logic [1:0] held_count_next;
  logic       wr_en;
  logic [1:0] wr_idx;
  logic       accept;
  logic [2:0] len_h;
  logic [2:0] len_b;
  logic [7:0] lead;

  assign raw_ready = !stat.full;
  assign accept    = raw_valid && raw_ready;
  assign push      = accept && (job.count != 3'd0);
  assign lead      = held_bytes[0];
  assign len_h     = u8r_pkg::lead_length(lead);
  assign len_b     = u8r_pkg::lead_length(in_byte);

  always_comb begin
    job             = '0;
    held_count_next = held_count;
    wr_en           = 1'b0;
    wr_idx          = held_count;
    if (mode) begin
      if (held_count != 2'd0) begin
        job.bytes[0] = u8r_pkg::REPL_0;
        job.bytes[1] = u8r_pkg::REPL_1;
        job.bytes[2] = u8r_pkg::REPL_2;
        job.count    = 3'd3;
      end
      held_count_next = 2'd0;
    end else if (held_count == 2'd0) begin
      if (len_b == u8r_pkg::LEN_BAD) begin
        job.bytes[0] = u8r_pkg::REPL_0;
        job.bytes[1] = u8r_pkg::REPL_1;
        job.bytes[2] = u8r_pkg::REPL_2;
        job.count    = 3'd3;
      end else if (len_b == u8r_pkg::LEN_1) begin
        job.bytes[0] = in_byte;
        job.count    = 3'd1;
      end else begin
        wr_en           = 1'b1;
        wr_idx          = 2'd0;
        held_count_next = 2'd1;
      end
    end else if (({1'b0, held_count} < len_h) &&
                 u8r_pkg::continues(lead, held_count, in_byte)) begin
      if (3'({1'b0, held_count} + 3'd1) == len_h) begin
        for (int i = 0; i < 3; i++) begin
          job.bytes[i] = (2'(i) < held_count) ? held_bytes[i] : in_byte;
        end
        job.bytes[3]    = in_byte;
        job.count       = 3'({1'b0, held_count} + 3'd1);
        held_count_next = 2'd0;
      end else begin
        wr_en           = 1'b1;
        held_count_next = 2'(held_count + 2'd1);
      end
    end else begin
      job.bytes[0]    = u8r_pkg::REPL_0;
      job.bytes[1]    = u8r_pkg::REPL_1;
      job.bytes[2]    = u8r_pkg::REPL_2;
      job.count       = 3'd3;
      held_count_next = 2'd0;
      if (len_b == u8r_pkg::LEN_BAD) begin
        job.bytes[3] = u8r_pkg::REPL_0;
        job.bytes[4] = u8r_pkg::REPL_1;
        job.bytes[5] = u8r_pkg::REPL_2;
        job.count    = 3'd6;
      end else if (len_b == u8r_pkg::LEN_1) begin
        job.bytes[3] = in_byte;
        job.count    = 3'd4;
      end else begin
        wr_en           = 1'b1;
        wr_idx          = 2'd0;
        held_count_next = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (accept) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      held_bytes[wr_idx] <= in_byte;
    end
  end

endmodule

[src/u8r_queue.sv]
// short run queue between front and back ends
// depends on u8r_pkg and assert_macros.svh
`include "assert_macros.svh"

module u8r_queue #(
  parameter int DEPTH = u8r_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8r_pkg::job_t     push_job,
  input  logic              pop,
  output u8r_pkg::job_t     head,
  output u8r_pkg::q_stat_t  stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  u8r_pkg::job_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [LW-1:0] level;

  assign head       = slots[rd_ptr];
  assign stat.full  = (level == LW'(DEPTH));
  assign stat.empty = (level == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        level <= LW'(level + 1'b1);
      end else if (pop && !push) begin
        level <= LW'(level - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  `U8R_ASSERT_NOW(a_no_overflow, push, !stat.full || pop, "queue overflow")
  `U8R_ASSERT_NOW(a_no_underflow, pop, !stat.empty, "queue underflow")
  `U8R_ASSERT_NEXT(a_level_up, push && !pop, level == LW'($past(level) + 1'b1), "level drift")

endmodule

[src/u8r_back.sv]
// back end: serialises queued runs into the output register
// depends on u8r_pkg and assert_macros.svh
`include "assert_macros.svh"

module u8r_back (
  input  logic              clk,
  input  logic              rst,
  input  u8r_pkg::job_t     head,
  input  u8r_pkg::q_stat_t  stat,
  output logic              pop,
  output logic              clean_valid,
  input  logic              clean_ready,
  output logic [7:0]        out_byte,
  output logic              run_last
);

  logic [2:0] idx;
  logic       load;
  logic       last;

  assign load = !stat.empty && (!clean_valid || clean_ready);
  assign last = (idx == 3'(head.count - 3'd1));
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      clean_valid <= 1'b0;
      idx         <= 3'd0;
    end else if (load) begin
      clean_valid <= 1'b1;
      idx         <= last ? 3'd0 : 3'(idx + 3'd1);
    end else if (clean_ready) begin
      clean_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head.bytes[idx];
      run_last <= last;
    end
  end

  `U8R_ASSERT_NOW(a_idx_bound, !stat.empty, idx < head.count, "index past run")
  `U8R_ASSERT_NOW(a_count_range, !stat.empty,
    head.count != 3'd0 && head.count <= 3'(u8r_pkg::MAX_RUN), "bad run length")
  `U8R_ASSERT_NOW(a_idx_idle, stat.empty, idx == 3'd0, "index left mid run")
  `U8R_ASSERT_NEXT(a_pop_last, pop, clean_valid && run_last, "pop without last byte")

endmodule

[src/utf8_stream_repair.sv]
// top level of the utf-8 stream repair block
// depends on u8r_pkg, u8r_in_if, u8r_out_if, u8r_front, u8r_queue, u8r_back
//
//   channel  dir  payload            meaning
//   raw      in   mode, in_byte      data byte or end-of-text flush
//   clean    out  out_byte, run_last repaired bytes, run_last ends a request's run
//
// one request accepted per cycle while the run queue has room
// a request yields 0 to 6 bytes, which the single-byte output register
// presents one at a time, holding each byte while the output stalls
// synchronous active-high reset clears the held count, queue and output valid
// the front end keeps accepting while the output stalls until the queue fills
module utf8_stream_repair #(
  parameter int QUEUE_DEPTH = u8r_pkg::QUEUE_DEPTH
) (
  input logic      clk,
  input logic      rst,
  u8r_in_if.sink   raw,
  u8r_out_if.source clean
);

  u8r_pkg::job_t    job;
  u8r_pkg::job_t    head;
  u8r_pkg::q_stat_t stat;
  logic             push;
  logic             pop;

  u8r_front u_front (
    .clk       (clk),
    .rst       (rst),
    .raw_valid (raw.valid),
    .raw_ready (raw.ready),
    .mode      (raw.mode),
    .in_byte   (raw.in_byte),
    .stat      (stat),
    .push      (push),
    .job       (job)
  );

  u8r_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  u8r_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .stat        (stat),
    .pop         (pop),
    .clean_valid (clean.valid),
    .clean_ready (clean.ready),
    .out_byte    (clean.out_byte),
    .run_last    (clean.run_last)
  );

endmodule
